// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, parse modes and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [3:0] {
        M_PLAIN   = 4'd0,
        M_ESC     = 4'd1,
        M_HEX1    = 4'd2,
        M_HEX2    = 4'd3,
        M_HEX3    = 4'd4,
        M_HEX4    = 4'd5,
        M_WANT_BS = 4'd6,
        M_WANT_U  = 4'd7,
        M_LO1     = 4'd8,
        M_LO2     = 4'd9,
        M_LO3     = 4'd10,
        M_LO4     = 4'd11,
        M_DROP    = 4'd12
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int MaxBytes = 4;

    // One input item's worth of results, at most four bytes.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] data;
        logic [2:0]               cnt;
        logic                     last;
        logic                     bad;
    } grp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexd_t;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] data;
        logic [2:0]               cnt;
    } utf8_t;

    function automatic hexd_t hex_digit(input logic [7:0] b);
        hexd_t r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h37);
        end
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.data[0] = cp[7:0];
            r.cnt     = 3'd1;
        end else if (cp < 21'h800) begin
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
            r.cnt     = 3'd2;
        end else if (cp < 21'h10000) begin
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
            r.cnt     = 3'd3;
        end else begin
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
            r.cnt     = 3'd4;
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsu_if.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape channels
// Valid/ready channels for raw input bytes and unescaped result bytes.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    logic       invalid;

    modport source (output valid, output out_byte, output last_out, output invalid,
                    input ready);
    modport sink (input valid, input out_byte, input last_out, input invalid,
                  output ready);
endinterface

// ===== rtl/json_string_unescape_unit.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape unit
// Unescapes a JSON string body byte by byte into UTF-8 with error marking.
// ----------------------------------------------------------------------------
// The first result byte of an item is registered and valid in the cycle after the item is taken.
// One input item is taken per cycle while each item yields at most one byte and the
// output is ready; an item that yields more bytes holds the input until its last byte
// is handed out, since the output stage hands out one byte per cycle while the output is ready.
// Reset: parse mode returns to plain bytes, escape state and output stage clear.
module json_string_unescape_unit
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jsu_in_if.sink      in_ch,
    jsu_out_if.source   out_ch
);

    logic push;
    logic room;
    grp_t grp;

    jsu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .room  (room),
        .push  (push),
        .grp   (grp)
    );

    jsu_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .grp    (grp),
        .room   (room),
        .out_ch (out_ch)
    );

    // An error result is always the single closing result of its string.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.invalid |-> out_ch.last_out && out_ch.out_byte == 8'h00)
    else $error("invalid result not closing the string");

    // With nothing pending the unit must take input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

    // A result group never exceeds four bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> grp.cnt <= 3'd4)
    else $error("result group too large");

    // An accepted item with results shows a valid byte on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && grp.cnt != 3'd0 |=> out_ch.valid)
    else $error("accepted results not presented");

endmodule

// ===== rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the parse state and turns one input byte into a group of results.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jsu_in_if.sink      in_ch,
    input  logic        room,
    output logic        push,
    output grp_t        grp
);

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [9:0]  hh_reg, hh_next;

    logic        err;
    logic        emit_cp;
    logic [20:0] cp;
    logic [15:0] acc;
    hexd_t       dig;
    utf8_t       enc;
    logic [7:0]  b;
    logic        last;

    assign in_ch.ready = room;
    assign push        = in_ch.valid && room;
    assign b           = in_ch.in_byte;
    assign last        = in_ch.last_in;
    assign dig         = hex_digit(b);
    assign acc         = {hex_reg[11:0], dig.val};

    always_comb
    begin
        err       = 1'b0;
        emit_cp   = 1'b0;
        cp        = {5'd0, acc};
        mode_next = mode_reg;
        hex_next  = hex_reg;
        hh_next   = hh_reg;
        grp       = '0;

        case (mode_reg)
            M_PLAIN:
            begin
                if (b == CH_BSL) begin
                    mode_next = M_ESC;
                end else if (b < CH_SPACE || b == CH_QUOTE) begin
                    err = 1'b1;
                end else begin
                    grp.data[0] = b;
                    grp.cnt     = 3'd1;
                end
            end
            M_ESC:
            begin
                mode_next = M_PLAIN;
                grp.cnt   = 3'd1;
                case (b)
                    CH_QUOTE: grp.data[0] = CH_QUOTE;
                    CH_BSL:   grp.data[0] = CH_BSL;
                    CH_SLASH: grp.data[0] = CH_SLASH;
                    CH_B:     grp.data[0] = 8'h08;
                    CH_F:     grp.data[0] = 8'h0C;
                    CH_N:     grp.data[0] = 8'h0A;
                    CH_R:     grp.data[0] = 8'h0D;
                    CH_T:     grp.data[0] = 8'h09;
                    CH_U:
                    begin
                        grp.cnt   = 3'd0;
                        hex_next  = '0;
                        mode_next = M_HEX1;
                    end
                    default:
                    begin
                        grp.cnt = 3'd0;
                        err     = 1'b1;
                    end
                endcase
            end
            M_WANT_BS:
            begin
                if (b == CH_BSL) mode_next = M_WANT_U;
                else err = 1'b1;
            end
            M_WANT_U:
            begin
                if (b == CH_U) begin
                    hex_next  = '0;
                    mode_next = M_LO1;
                end else begin
                    err = 1'b1;
                end
            end
            M_HEX1, M_HEX2, M_HEX3, M_LO1, M_LO2, M_LO3:
            begin
                if (!dig.ok) begin
                    err = 1'b1;
                end else begin
                    hex_next  = acc;
                    mode_next = mode_t'(4'(mode_reg) + 4'd1);
                end
            end
            M_HEX4:
            begin
                if (!dig.ok) begin
                    err = 1'b1;
                end else begin
                    hex_next = acc;
                    if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                        hh_next   = acc[9:0];
                        mode_next = M_WANT_BS;
                    end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                        err = 1'b1;
                    end else begin
                        emit_cp   = 1'b1;
                        mode_next = M_PLAIN;
                    end
                end
            end
            M_LO4:
            begin
                if (!dig.ok) begin
                    err = 1'b1;
                end else begin
                    hex_next = acc;
                    if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                        // Supplementary plane: 0x10000 + high half and low ten bits.
                        cp        = 21'h10000 + {1'b0, hh_reg, acc[9:0]};
                        emit_cp   = 1'b1;
                        mode_next = M_PLAIN;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = M_DROP;
            end
        endcase

        enc = utf8_enc(cp);
        if (emit_cp) begin
            grp.data = enc.data;
            grp.cnt  = enc.cnt;
        end

        // A string that ends part way through an escape is malformed.
        if (!err && last && mode_next != M_PLAIN && mode_next != M_DROP) begin
            err = 1'b1;
        end

        if (err) begin
            grp.data  = '0;
            grp.cnt   = 3'd1;
            grp.bad   = 1'b1;
            grp.last  = 1'b1;
            mode_next = last ? M_PLAIN : M_DROP;
        end else if (last) begin
            grp.last  = 1'b1;
            mode_next = M_PLAIN;
        end

        if (last) begin
            hex_next = '0;
            hh_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_PLAIN;
            hex_reg  <= '0;
            hh_reg   <= '0;
        end else if (push) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            hh_reg   <= hh_next;
        end
    end

endmodule

// ===== rtl/jsu_serial.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape output stage
// Registers a result group and hands its bytes out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module jsu_serial
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  grp_t        grp,
    output logic        room,
    jsu_out_if.source   out_ch
);

    logic [MaxBytes-1:0][7:0] data_reg, data_next;
    logic [2:0]               rem_reg, rem_next;
    logic                     last_reg, last_next;
    logic                     bad_reg, bad_next;
    logic                     fire;

    assign fire            = (rem_reg != 3'd0) && out_ch.ready;
    assign room            = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ch.ready);
    assign out_ch.valid    = rem_reg != 3'd0;
    assign out_ch.out_byte = data_reg[0];
    assign out_ch.last_out = last_reg && rem_reg == 3'd1;
    assign out_ch.invalid  = bad_reg;

    always_comb
    begin
        data_next = data_reg;
        rem_next  = rem_reg;
        last_next = last_reg;
        bad_next  = bad_reg;
        if (fire) begin
            data_next = {8'h00, data_reg[MaxBytes-1:1]};
            rem_next  = rem_reg - 3'd1;
        end
        // An item with no result leaves the stage untouched.
        if (push && grp.cnt != 3'd0) begin
            data_next = grp.data;
            rem_next  = grp.cnt;
            last_next = grp.last;
            bad_next  = grp.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= '0;
            last_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            last_reg <= last_next;
            bad_reg  <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
